[design/bti_pkg.sv]
// Package for the brace text reindenter.
// Holds the byte codes, field widths and the run descriptor shared by the decoder and emitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bti_pkg;

  // Field widths.
  localparam int unsigned CharW  = 8;
  localparam int unsigned DepthW = 4;
  localparam int unsigned SpaceW = 5;

  // Largest depth that the indent register can hold.
  localparam logic [DepthW-1:0] DEPTH_LIMIT = 4'd15;

  // Byte codes.
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_OPEN  = 8'h7B;
  localparam logic [CharW-1:0] CH_CLOSE = 8'h7D;
  localparam logic [CharW-1:0] CH_NL    = 8'h0A;
  localparam logic [CharW-1:0] CH_SP    = 8'h20;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;

  // One output run: optional newline and spaces, then the byte itself.
  typedef struct packed {
    logic              emit;
    logic              newline;
    logic [SpaceW-1:0] spaces;
    logic [CharW-1:0]  ch;
  } run_desc_t;

endpackage

`default_nettype wire

[design/bti_in_if.sv]
// Input channel of the brace text reindenter: one text byte per word.
// Depends on bti_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bti_in_if;
  logic                       valid;
  logic                       ready;
  logic [bti_pkg::CharW-1:0]  char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

`default_nettype wire

[design/bti_out_if.sv]
// Output channel of the brace text reindenter: one output byte per word, last of run marked.
// Depends on bti_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bti_out_if;
  logic                       valid;
  logic                       ready;
  logic [bti_pkg::CharW-1:0]  char_out;
  logic                       run_last;

  modport source (output valid, output char_out, output run_last, input ready);
  modport sink (input valid, input char_out, input run_last, output ready);
endinterface

`default_nettype wire

[design/bti_decode.sv]
// Decoder of the brace text reindenter: keeps indent depth and skip mode, and turns
// each input byte into a run descriptor. Depends on bti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bti_decode #(
  parameter int unsigned MAX_DEPTH = 15
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [bti_pkg::CharW-1:0]  char_in,
  input  wire logic                       accept,
  output bti_pkg::run_desc_t              desc
);

  localparam logic [bti_pkg::DepthW-1:0] DepthCap =
    (MAX_DEPTH < 15) ? bti_pkg::DepthW'(MAX_DEPTH) : bti_pkg::DEPTH_LIMIT;

  logic [bti_pkg::DepthW-1:0] indent_level;
  logic [bti_pkg::DepthW-1:0] indent_level_next;
  logic                       skipping_ws;
  logic                       skipping_ws_next;

  logic is_comma;
  logic is_open;
  logic is_close;
  logic is_special;
  logic is_ws;
  logic drop;
  logic [bti_pkg::DepthW-1:0] indent_used;

  // Classify the byte.
  always_comb begin
    is_comma   = (char_in == bti_pkg::CH_COMMA);
    is_open    = (char_in == bti_pkg::CH_OPEN);
    is_close   = (char_in == bti_pkg::CH_CLOSE);
    is_special = is_comma || is_open || is_close;
    is_ws      = ((char_in >= bti_pkg::CH_TAB) && (char_in <= bti_pkg::CH_CR)) ||
                 (char_in == bti_pkg::CH_SP);
    drop       = skipping_ws && is_ws;
  end

  // Next depth and skip mode. A closing brace indents at the lowered depth.
  always_comb begin
    indent_level_next = indent_level;
    if (!drop && is_open && (indent_level < DepthCap)) begin
      indent_level_next = indent_level + 1'b1;
    end else if (!drop && is_close && (indent_level != '0)) begin
      indent_level_next = indent_level - 1'b1;
    end
    indent_used      = is_close ? indent_level_next : indent_level;
    skipping_ws_next = drop ? 1'b1 : is_special;
  end

  // Run descriptor for the emitter.
  always_comb begin
    desc.emit    = !drop;
    desc.newline = is_open || is_close || (skipping_ws && !is_special);
    desc.spaces  = {indent_used, 1'b0};
    desc.ch      = char_in;
  end

  // State update on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      indent_level <= '0;
      skipping_ws  <= 1'b0;
    end else if (accept) begin
      indent_level <= indent_level_next;
      skipping_ws  <= skipping_ws_next;
    end
  end

endmodule

`default_nettype wire

[design/bti_emit.sv]
// Emitter of the brace text reindenter: plays out one run descriptor as optional newline and
// spaces, then the byte, one word per cycle while the output is ready. Depends on bti_pkg and bti_out_if.
`timescale 1ns / 1ps
`default_nettype none

module bti_emit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bti_pkg::run_desc_t desc,
  input  wire logic               load,
  output logic                    load_ok,
  bti_out_if.source               out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_NL   = 4'b0010,
    S_SP   = 4'b0100,
    S_CH   = 4'b1000
  } emit_state_t;

  emit_state_t                       state;
  emit_state_t                       state_next;
  logic [bti_pkg::SpaceW-1:0]        cnt;
  logic [bti_pkg::SpaceW-1:0]        cnt_next;
  logic [bti_pkg::CharW-1:0]         ch;
  logic [bti_pkg::CharW-1:0]         ch_next;

  // A new run may load once the current one hands over its last word.
  assign load_ok = (state == S_IDLE) || ((state == S_CH) && out_ch.ready);

  // Output word from the current phase.
  always_comb begin
    out_ch.valid    = (state != S_IDLE);
    out_ch.run_last = (state == S_CH);
    unique case (state)
      S_NL:    out_ch.char_out = bti_pkg::CH_NL;
      S_SP:    out_ch.char_out = bti_pkg::CH_SP;
      default: out_ch.char_out = ch;
    endcase
  end

  // Phase sequencing.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ch_next    = ch;
    if (load) begin
      ch_next  = desc.ch;
      cnt_next = desc.spaces;
      if (!desc.emit) begin
        state_next = S_IDLE;
      end else if (desc.newline) begin
        state_next = S_NL;
      end else begin
        state_next = S_CH;
      end
    end else if (out_ch.ready) begin
      unique case (state)
        S_NL: begin
          state_next = (cnt != '0) ? S_SP : S_CH;
        end
        S_SP: begin
          cnt_next = cnt - 1'b1;
          if (cnt == bti_pkg::SpaceW'(1)) begin
            state_next = S_CH;
          end
        end
        S_CH:    state_next = S_IDLE;
        default: state_next = S_IDLE;
      endcase
    end
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Space count and held byte; only read while a run is active.
  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    ch  <= ch_next;
  end

`ifndef ASSERT_OFF
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_NL || state == S_SP) |-> !load_ok)
    else $error("input taken in the middle of a run");

  a_nl_then_sp_or_ch: assert property (@(posedge clk) disable iff (rst)
    (state == S_NL && out_ch.ready) |=> (state == S_SP || state == S_CH))
    else $error("newline not followed by indent or byte");

  a_sp_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SP) |-> (cnt != '0))
    else $error("space phase with empty count");

  a_last_space_to_ch: assert property (@(posedge clk) disable iff (rst)
    (state == S_SP && out_ch.ready && cnt == bti_pkg::SpaceW'(1)) |=> (state == S_CH))
    else $error("last space not followed by the byte");
`endif

endmodule

`default_nettype wire

[design/brace_text_reindenter.sv]
// Top level of the brace text reindenter: decoder with depth and skip state, and the run emitter.
// Depends on bti_pkg, bti_in_if, bti_out_if, bti_decode and bti_emit.
//
//   Channel  Dir  Payload             Meaning
//   in_ch    in   char_in[7:0]        one text byte
//   out_ch   out  char_out[7:0],      one output byte
//                 run_last            last byte of the run for one input byte
//
// An input byte gives a run of 0 to 32 output words.
// A byte copied one for one flows at one byte per cycle while the output is ready; a line break
// adds a newline word and two spaces per depth level, which the emitter sends one word per cycle.
// A dropped whitespace byte is taken and gives nothing.
// Synchronous reset clears depth, skip mode and the emitter; output stalls hold the run.
`timescale 1ns / 1ps
`default_nettype none

module brace_text_reindenter #(
  parameter int unsigned MAX_DEPTH = 15
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bti_in_if.sink     in_ch,
  bti_out_if.source  out_ch
);

  bti_pkg::run_desc_t desc;
  logic               load_ok;
  logic               accept;

  // A byte is taken whenever the emitter can load its run.
  assign in_ch.ready = load_ok;
  assign accept      = in_ch.valid && load_ok;

  // Byte classification and state.
  bti_decode #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_decode (
    .clk    (clk),
    .rst    (rst),
    .char_in(in_ch.char_in),
    .accept (accept),
    .desc   (desc)
  );

  // Run playout.
  bti_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .desc   (desc),
    .load   (accept),
    .load_ok(load_ok),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
